### hw/rtl/rar_pkg.sv
package rar_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GCD_A,
        ST_DIV_NA,
        ST_DIV_DA,
        ST_GCD_B,
        ST_DIV_NB,
        ST_DIV_DB,
        ST_GCD_AB,
        ST_DIV_QA,
        ST_DIV_QB,
        ST_MUL_DEN,
        ST_MUL_SA,
        ST_MUL_SB,
        ST_OUT
    } rar_state_t;

    typedef struct packed {
        logic start;
    } rar_div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rar_div_sts_t;

endpackage

### hw/rtl/rational_add_reduced_unit.sv
// sequencing: each euclid step and each of the 6 exact divisions runs on the single shared
//   restoring divider, each gcd ends with a zero-remainder check, then come 3 multiply steps,
//   the accept step and the result beat; the total time is data dependent, longer when all
//   three gcds run long euclid chains
// throughput: one item at a time, s_tready high only when idle; next item after result beat
// reset: aresetn synchronous, clears sequencer, divider control and m_tvalid; no clearing pass
module rational_add_reduced_unit #(
    parameter int OPERAND_BITS = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // num_a, den_a, num_b, den_b from bit 0 up
    input  logic [((4*OPERAND_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // sum_num (2n+1 bits), sum_den (2n bits) from bit 0 up
    output logic [((4*OPERAND_BITS+8)/8)*8-1:0]      m_tdata
);
    import rar_pkg::*;

    localparam int N     = OPERAND_BITS;
    localparam int OUT_W = ((4*N+8)/8)*8;

    rar_state_t   state_reg, state_next;
    logic         launched_reg, launched_next;
    logic [N-1:0] na_reg, na_next, da_reg, da_next;
    logic [N-1:0] nb_reg, nb_next, db_reg, db_next;
    logic [N-1:0] x_reg, x_next, y_reg, y_next;
    logic [N-1:0] qa_reg, qa_next, qb_reg, qb_next;
    logic [2*N-1:0] common_reg, common_next;
    logic [2*N:0]   sum_reg, sum_next;

    rar_div_cmd_t div_cmd;
    rar_div_sts_t div_sts;
    logic [N-1:0] div_dividend, div_divisor, div_quo, div_rem;
    logic [N-1:0] mul_a, mul_b;
    logic [2*N-1:0] prod;
    logic [N-1:0] in_na, in_da, in_nb, in_db;

    assign in_na = s_tdata[N-1:0];
    assign in_da = s_tdata[2*N-1:N];
    assign in_nb = s_tdata[3*N-1:2*N];
    assign in_db = s_tdata[4*N-1:3*N];

    rar_div #(.W(N)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (div_cmd),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .sts       (div_sts),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign prod = mul_a * mul_b;

    always_comb begin
        state_next    = state_reg;
        launched_next = launched_reg;
        na_next = na_reg;  da_next = da_reg;
        nb_next = nb_reg;  db_next = db_reg;
        x_next  = x_reg;   y_next  = y_reg;
        qa_next = qa_reg;  qb_next = qb_reg;
        common_next   = common_reg;
        sum_next      = sum_reg;
        div_cmd.start = 1'b0;
        div_dividend  = x_reg;
        div_divisor   = x_reg;
        mul_a         = qa_reg;
        mul_b         = db_reg;

        unique case (state_reg)
            ST_DIV_NA: div_dividend = na_reg;
            ST_DIV_DA: div_dividend = da_reg;
            ST_DIV_NB: div_dividend = nb_reg;
            ST_DIV_DB: div_dividend = db_reg;
            ST_DIV_QA: div_dividend = da_reg;
            ST_DIV_QB: div_dividend = db_reg;
            default:   div_dividend = x_reg;
        endcase

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    na_next = in_na;
                    nb_next = in_nb;
                    // a zero denominator counts as one
                    da_next = (in_da == '0) ? N'(1) : in_da;
                    db_next = (in_db == '0) ? N'(1) : in_db;
                    x_next  = in_na;
                    y_next  = (in_da == '0) ? N'(1) : in_da;
                    launched_next = 1'b0;
                    state_next    = ST_GCD_A;
                end
            end
            ST_GCD_A, ST_GCD_B, ST_GCD_AB: begin
                // euclid step: x mod y
                div_divisor = y_reg;
                if (!launched_reg) begin
                    if (y_reg == '0) begin
                        unique case (state_reg)
                            ST_GCD_A: state_next = ST_DIV_NA;
                            ST_GCD_B: state_next = ST_DIV_NB;
                            default:  state_next = ST_DIV_QA;
                        endcase
                    end else begin
                        div_dividend  = x_reg;
                        div_cmd.start = 1'b1;
                        launched_next = 1'b1;
                    end
                end else if (div_sts.done) begin
                    x_next = y_reg;
                    y_next = div_rem;
                    launched_next = 1'b0;
                end
            end
            ST_DIV_NA, ST_DIV_DA, ST_DIV_NB, ST_DIV_DB, ST_DIV_QA, ST_DIV_QB: begin
                if (!launched_reg) begin
                    div_cmd.start = 1'b1;
                    launched_next = 1'b1;
                end else if (div_sts.done) begin
                    launched_next = 1'b0;
                    unique case (state_reg)
                        ST_DIV_NA: begin
                            na_next = div_quo;
                            state_next = ST_DIV_DA;
                        end
                        ST_DIV_DA: begin
                            da_next = div_quo;
                            x_next  = nb_reg;
                            y_next  = db_reg;
                            state_next = ST_GCD_B;
                        end
                        ST_DIV_NB: begin
                            nb_next = div_quo;
                            state_next = ST_DIV_DB;
                        end
                        ST_DIV_DB: begin
                            db_next = div_quo;
                            x_next  = da_reg;
                            y_next  = div_quo;
                            state_next = ST_GCD_AB;
                        end
                        ST_DIV_QA: begin
                            qa_next = div_quo;
                            state_next = ST_DIV_QB;
                        end
                        default: begin
                            qb_next = div_quo;
                            state_next = ST_MUL_DEN;
                        end
                    endcase
                end
            end
            ST_MUL_DEN: begin
                mul_a = qa_reg;
                mul_b = db_reg;
                common_next = prod;
                state_next  = ST_MUL_SA;
            end
            ST_MUL_SA: begin
                // common / da equals db / g
                mul_a = na_reg;
                mul_b = qb_reg;
                sum_next   = {1'b0, prod};
                state_next = ST_MUL_SB;
            end
            ST_MUL_SB: begin
                mul_a = nb_reg;
                mul_b = qa_reg;
                sum_next   = sum_reg + {1'b0, prod};
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        na_reg <= na_next;  da_reg <= da_next;
        nb_reg <= nb_next;  db_reg <= db_next;
        x_reg  <= x_next;   y_reg  <= y_next;
        qa_reg <= qa_next;  qb_reg <= qb_next;
        common_reg <= common_next;
        sum_reg    <= sum_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            launched_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {{(OUT_W-4*N-1){1'b0}}, common_reg, sum_reg};

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and result sides open together");
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> common_reg != '0)
        else $error("common denominator is zero");
    a_done_launched: assert property (@(posedge aclk) disable iff (!aresetn)
        div_sts.done |-> launched_reg)
        else $error("division finished with nothing launched");
    a_gcd_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_cmd.start && state_reg != ST_GCD_A && state_reg != ST_GCD_B
         && state_reg != ST_GCD_AB) |-> x_reg != '0)
        else $error("reduction divides by zero gcd");

endmodule

### hw/rtl/rar_div.sv
module rar_div #(
    parameter int W = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rar_pkg::rar_div_cmd_t cmd,
    input  logic [W-1:0]          dividend,
    input  logic [W-1:0]          divisor,
    output rar_pkg::rar_div_sts_t sts,
    output logic [W-1:0]          quotient,
    output logic [W-1:0]          remainder
);
    import rar_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic          fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? W'(trial - {1'b0, dvs_reg}) : trial[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_cnt_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0)
        else $error("divider step count ran out while busy");

endmodule

### tb/sv/rational_add_reduced_checker.sv
module rational_add_reduced_checker #(
    parameter int OPERAND_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [((4*OPERAND_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [((4*OPERAND_BITS+8)/8)*8-1:0] m_tdata,
    output int                                  fail_count,
    output int                                  pending
);
    localparam int NB = OPERAND_BITS;

    typedef struct packed {
        logic [2*NB:0]   sum_num;
        logic [2*NB-1:0] sum_den;
    } frac_sum_t;

    frac_sum_t sums_due[$];
    int fails = 0;

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic frac_sum_t add_fractions(logic [4*NB-1:0] d);
        logic [63:0] na, da, nb, db, g, lcm;
        frac_sum_t res;
        na = 64'(d[NB-1:0]);
        da = 64'(d[2*NB-1:NB]);
        nb = 64'(d[3*NB-1:2*NB]);
        db = 64'(d[4*NB-1:3*NB]);
        if (da == 0) da = 1;
        if (db == 0) db = 1;
        g = gcd64(na, da);
        if (g > 1) begin
            na = na / g;
            da = da / g;
        end
        g = gcd64(nb, db);
        if (g > 1) begin
            nb = nb / g;
            db = db / g;
        end
        g = gcd64(da, db);
        lcm = (da / g) * db;
        res.sum_num = (2*NB+1)'(na * (lcm / da) + nb * (lcm / db));
        res.sum_den = (2*NB)'(lcm);
        return res;
    endfunction

    assign fail_count = fails;

    always @(posedge aclk) begin
        frac_sum_t want;
        logic [2*NB:0]   got_num;
        logic [2*NB-1:0] got_den;
        int bad;
        bad = 0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got_num = m_tdata[2*NB:0];
                got_den = m_tdata[4*NB:2*NB+1];
                if (sums_due.size() == 0) begin
                    $error("result beat with nothing expected");
                    bad++;
                end else begin
                    want = sums_due.pop_front();
                    if (got_num !== want.sum_num) begin
                        $error("sum_num expected %0d actual %0d", want.sum_num, got_num);
                        bad++;
                    end
                    if (got_den !== want.sum_den) begin
                        $error("sum_den expected %0d actual %0d", want.sum_den, got_den);
                        bad++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                sums_due.push_back(add_fractions(s_tdata[4*NB-1:0]));
        end
        if (bad != 0)
            fails <= fails + bad;
        pending <= sums_due.size();
    end
endmodule

### tb/sv/rational_add_reduced_unit_tb.sv
module rational_add_reduced_unit_tb;
    localparam int NB = 16;
    localparam int SW = ((4*NB+7)/8)*8;
    localparam int MW = ((4*NB+8)/8)*8;
    localparam int IDLE_LIMIT = 20000;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [MW-1:0] m_tdata;
    int fail_count, pending;
    int idle_cycles = 0;
    bit stim_done = 0;

    always #5 aclk = ~aclk;

    rational_add_reduced_unit #(.OPERAND_BITS(NB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    rational_add_reduced_checker #(.OPERAND_BITS(NB)) chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 4);
    endfunction

    function automatic logic [NB-1:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return NB'($urandom_range(1, 12));
            3: return NB'($urandom_range(0, 255));
            default: return NB'($urandom);
        endcase
    endfunction

    // one input beat, held until accepted; tvalid drops only when a gap follows
    task automatic send_fractions(logic [NB-1:0] na, logic [NB-1:0] da,
                                  logic [NB-1:0] nb, logic [NB-1:0] db);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= SW'({db, nb, da, na});
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if ($urandom_range(0, 49) == 0) m_tready <= 0;
        else if ($urandom_range(0, 3) == 0) m_tready <= ~m_tready;
        else m_tready <= m_tready | ($urandom_range(0, 1) == 1);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("rational_add_reduced_unit_tb NOT OK");
            $finish;
        end
    end

    initial begin
        logic [NB-1:0] a, b;
        repeat (11) @(negedge aclk);
        aresetn <= 1;
        // extremes, zero numerators, zero denominators, reducible pairs
        send_fractions(16'd0, 16'd1, 16'd0, 16'd1);
        send_fractions('1, '1, '1, '1);
        send_fractions('1, 16'd1, '1, 16'd1);
        send_fractions(16'd0, 16'd0, 16'd0, 16'd0);
        send_fractions('1, 16'd0, 16'd5, 16'd0);
        send_fractions(16'd0, '1, 16'd3, 16'd7);
        send_fractions(16'd7, 16'd3, 16'd0, '1);
        send_fractions(16'd1, '1, 16'd1, 16'hfffe);
        send_fractions(16'd6, 16'd8, 16'd9, 16'd12);
        send_fractions(16'd1, 16'd65521, 16'd1, 16'd65519);
        send_fractions(16'h8000, 16'h4000, 16'h5555, 16'haaaa);
        send_fractions(16'd1, 16'd2, 16'd1, 16'd2);
        send_fractions('1, 16'hfffe, '1, 16'hfffd);
        send_fractions(16'd12, 16'd12, 16'd0, 16'd5);
        for (int i = 0; i < 1000; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                // share a factor so the reductions and gcd do real work
                a = NB'($urandom_range(1, 300));
                b = NB'($urandom_range(1, 200));
                send_fractions(NB'(a * $urandom_range(0, 200)), NB'(a * b),
                               NB'(b * $urandom_range(0, 200)), NB'(b * $urandom_range(1, 300)));
            end else begin
                send_fractions(rand_operand(), rand_operand(), rand_operand(), rand_operand());
            end
        end
        s_tvalid <= 0;
        wait (pending == 0);
        repeat (500) @(posedge aclk);
        if (fail_count == 0)
            $display("rational_add_reduced_unit_tb OK");
        else
            $display("rational_add_reduced_unit_tb NOT OK");
        $finish;
    end
endmodule
